FILE: hdl/swg_pkg.sv
// Shared types, mode codes and the half-sine coefficient table for the
// scaled waveform generator. No dependencies.
package swg_pkg;

    typedef logic [11:0] t_sample;
    typedef logic [1:0]  t_mode;
    typedef logic [4:0]  t_step;
    typedef logic [12:0] t_coef;

    localparam t_mode MODE_IDLE   = 2'd0;
    localparam t_mode MODE_SQUARE = 2'd1;
    localparam t_mode MODE_SAW    = 2'd2;
    localparam t_mode MODE_SINE   = 2'd3;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_PRESS = 1'b1;

    function automatic t_coef sine_coef(input logic [3:0] idx);
        t_coef c;
        unique case (idx)
            4'd0:    c = 13'd0;
            4'd1:    c = 13'd799;
            4'd2:    c = 13'd1567;
            4'd3:    c = 13'd2275;
            4'd4:    c = 13'd2896;
            4'd5:    c = 13'd3405;
            4'd6:    c = 13'd3784;
            4'd7:    c = 13'd4017;
            4'd8:    c = 13'd4096;
            4'd9:    c = 13'd4017;
            4'd10:   c = 13'd3784;
            4'd11:   c = 13'd3405;
            4'd12:   c = 13'd2896;
            4'd13:   c = 13'd2275;
            4'd14:   c = 13'd1567;
            default: c = 13'd799;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/swg_if.sv
// Valid/ready channel interfaces for the waveform generator: request beats in,
// sample beats out. Depends on swg_pkg.
interface swg_req_if;
    import swg_pkg::*;
    logic    valid;
    logic    ready;
    logic    req_type;
    t_sample amplitude;

    modport source (output valid, output req_type, output amplitude, input ready);
    modport sink   (input valid, input req_type, input amplitude, output ready);
endinterface

interface swg_smp_if;
    import swg_pkg::*;
    logic    valid;
    logic    ready;
    t_sample dac_value;
    t_mode   active_mode;
    logic    period_start;

    modport source (output valid, output dac_value, output active_mode,
                    output period_start, input ready);
    modport sink   (input valid, input dac_value, input active_mode,
                    input period_start, output ready);
endinterface

FILE: hdl/scaled_waveform_generator_unit.sv
// Scaled waveform generator top level: mode state, step counter, sample
// arithmetic and output register. Depends on swg_pkg and swg_if.
//
// Usage:
//   i_req carries one beat per sample tick (req_type 0, with the 12-bit
//   amplitude) or per button press (req_type 1). A press advances the
//   requested mode 0-1-2-3-0 and gives no sample; the new mode starts at the
//   end of the running period. A tick in square, saw or sine mode gives one
//   beat on o_smp with the DAC value, the mode that made it and a flag for
//   step 0 of the period; a tick while idle gives nothing.
//   A request beat is held in the input register, then its sample in the
//   output register, which offers it on o_smp. Throughput: one beat per
//   cycle while o_smp is not stalled; the step counter, a 13x12 (sine) and
//   a 4x12 (saw) multiply and the mode update sit between the registers.
//   Reset (synchronous, i_rst_n low) empties both registers, sets the mode
//   to idle and the step to 0.
//   When the receiver stalls, the sample holds in the output register; a
//   press beat or a tick that gives no sample still drains, and a further
//   request beat is taken only once the input register can move on.
module scaled_waveform_generator_unit (
    input  logic  i_clk,
    input  logic  i_rst_n,
    swg_req_if.sink   i_req,
    swg_smp_if.source o_smp
);
    import swg_pkg::*;

    logic    r_in_valid;
    logic    r_req_type;
    t_sample r_amp;

    t_mode   r_cur_mode;
    t_mode   r_req_mode;
    t_step   r_step;

    logic    r_out_valid;
    t_sample r_dac;
    t_mode   r_out_mode;
    logic    r_out_start;

    t_mode          w_mode;
    t_step          w_step;
    t_step          w_step_inc;
    logic           w_period_end;
    logic           w_emit;
    logic           w_out_free;
    logic           w_adv;
    logic [15:0]    w_saw_prod;
    logic [24:0]    w_sine_prod;
    t_sample        w_sample;

    assign w_mode       = (r_cur_mode == MODE_IDLE) ? r_req_mode : r_cur_mode;
    assign w_step       = (r_cur_mode == MODE_IDLE) ? 5'd0 : r_step;
    assign w_step_inc   = w_step + 5'd1;
    assign w_period_end = (w_step_inc == 5'd0) ||
                          ((w_mode != MODE_SINE) && w_step_inc[4]);

    assign w_emit     = r_in_valid && (r_req_type == REQ_TICK) && (w_mode != MODE_IDLE);
    assign w_out_free = !r_out_valid || o_smp.ready;
    assign w_adv      = r_in_valid && (!w_emit || w_out_free);

    assign i_req.ready = !r_in_valid || w_adv;

    assign w_saw_prod  = 16'(w_step[3:0]) * 16'(r_amp);
    assign w_sine_prod = 25'(sine_coef(w_step[3:0])) * 25'(r_amp);

    always_comb begin
        case (w_mode)
            MODE_SQUARE: w_sample = w_step[3] ? 12'd0 : r_amp;
            MODE_SAW:    w_sample = w_saw_prod[15:4];
            MODE_SINE:   w_sample = w_step[4] ? 12'd0 : w_sine_prod[23:12];
            default:     w_sample = 12'd0;
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
        if (i_req.valid && i_req.ready) begin
            r_req_type <= i_req.req_type;
            r_amp      <= i_req.amplitude;
        end
    end

    // mode and step state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_mode <= MODE_IDLE;
            r_req_mode <= MODE_IDLE;
            r_step     <= 5'd0;
        end else if (w_adv) begin
            if (r_req_type == REQ_PRESS) begin
                r_req_mode <= (r_req_mode == MODE_SINE) ? MODE_IDLE : r_req_mode + 2'd1;
            end else if (w_mode != MODE_IDLE) begin
                if (w_period_end) begin
                    r_step     <= 5'd0;
                    r_cur_mode <= r_req_mode;
                end else begin
                    r_step     <= w_step_inc;
                    r_cur_mode <= w_mode;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_smp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv && w_emit) begin
            r_dac       <= w_sample;
            r_out_mode  <= w_mode;
            r_out_start <= (w_step == 5'd0);
        end
    end

    assign o_smp.valid        = r_out_valid;
    assign o_smp.dac_value    = r_dac;
    assign o_smp.active_mode  = r_out_mode;
    assign o_smp.period_start = r_out_start;

    a_idle_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_mode == MODE_IDLE) |-> (r_step == 5'd0))
        else $error("step counter running while idle");

    a_short_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_mode != MODE_SINE) |-> !r_step[4])
        else $error("step beyond a 16-step period");

    a_out_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_mode != MODE_IDLE))
        else $error("sample beat from idle mode");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_amp) && $stable(r_req_type)))
        else $error("stalled request lost");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_smp.ready) |=> (r_out_valid && $stable(r_dac)))
        else $error("pending sample overwritten");

endmodule
